### hdl/pbt_pkg.sv
// Package for the wire-format field tokenizer: beat types, byte token
// passed from the front end to the decoder, phase and result-kind codes.
package pbt_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef enum logic [1:0] {
        KIND_VARINT = 2'd0,
        KIND_LEN    = 2'd1,
        KIND_OK     = 2'd2,
        KIND_ERR    = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] field_number;
        logic [63:0] field_value;
        logic [15:0] payload_offset;
        logic        final_res;
    } t_res;

    // Classified byte as queued between front end and decoder
    typedef struct packed {
        logic [6:0]  low7;
        logic        cont;
        logic        last;
        logic        too_long;
        logic [15:0] pos;      // message position after this byte, mod 2^16
    } t_tok;

    typedef enum logic [2:0] {
        PH_TAG    = 3'd0,
        PH_VALUE  = 3'd1,
        PH_LENGTH = 3'd2,
        PH_SKIP   = 3'd3,
        PH_DRAIN  = 3'd4
    } t_phase;

    localparam logic [3:0] VARINT_LAST_IDX = 4'd9;   // tenth byte of a varint
    localparam int unsigned QUEUE_DEPTH    = 4;

endpackage

### hdl/pbt_front.sv
// Front end: takes message bytes, tracks position within the message and
// flags over-length bytes. Depends on pbt_pkg.
module pbt_front import pbt_pkg::*; #(
    parameter int unsigned MAX_MESSAGE_BYTES = 65536
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    input  logic i_q_full,
    output logic o_push,
    output t_tok o_tok
);

    localparam int unsigned CW = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam logic [CW-1:0] MAX_IDX = CW'(MAX_MESSAGE_BYTES);

    logic [CW-1:0] r_idx, n_idx;
    logic [CW:0]   idx_inc;
    logic          at_max;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign at_max  = (r_idx == MAX_IDX);
    assign idx_inc = {1'b0, r_idx} + {{CW{1'b0}}, 1'b1};

    always_comb begin
        o_tok.low7     = i_data.data_byte[6:0];
        o_tok.cont     = i_data.data_byte[7];
        o_tok.last     = i_data.last_byte;
        o_tok.too_long = at_max;
        o_tok.pos      = 16'(idx_inc);
    end

    // Counter restarts after every last byte, saturates at the size limit
    always_comb begin
        n_idx = r_idx;
        if (o_push) begin
            if (i_data.last_byte) begin
                n_idx = '0;
            end else if (!at_max) begin
                n_idx = idx_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

### hdl/pbt_fifo.sv
// Short token queue between front end and decoder.
// Depends on pbt_pkg (t_tok).
module pbt_fifo import pbt_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_tok i_tok,
    input  logic i_pop,
    output t_tok o_tok,
    output logic o_full,
    output logic o_empty
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned NW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [NW-1:0] FULL_CNT = NW'(DEPTH);

    t_tok          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [NW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_tok   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("token queue count beyond depth");

endmodule

### hdl/pbt_back.sv
// Decoder: pops byte tokens, runs the tag/varint/skip state machine and
// drives the result register. Depends on pbt_pkg.
module pbt_back import pbt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_tok i_tok,
    input  logic i_empty,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    t_phase      r_phase, n_phase;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_sc, n_sc;
    logic [31:0] r_field, n_field;
    logic [63:0] r_skip, n_skip;

    logic        r_out_valid;
    t_res        r_out;
    logic        r_pend, r_pend_err;

    logic        out_free;
    logic [5:0]  shamt;
    logic [63:0] acc_new;
    logic [2:0]  wt;
    logic        bad_wt, vint_over, err, ends_clean, draining;
    logic        field_emit, final_emit, final_err;
    t_res        field_res, final_out;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = !i_empty && out_free && !r_pend;
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;

    // Shared decode of the head token
    always_comb begin
        shamt     = {r_sc[2:0], 3'b000} - {3'b000, r_sc[2:0]} + (r_sc[3] ? 6'd56 : 6'd0);
        acc_new   = r_acc | (64'(i_tok.low7) << shamt);
        wt        = acc_new[2:0];
        bad_wt    = wt inside {3'd3, 3'd4, 3'd6, 3'd7};
        vint_over = i_tok.cont && (r_sc >= VARINT_LAST_IDX);
        draining  = (r_phase == PH_DRAIN);
        err        = 1'b0;
        ends_clean = 1'b0;
        case (r_phase)
            PH_TAG: begin
                err = vint_over || (!i_tok.cont && bad_wt);
            end
            PH_VALUE: begin
                err        = vint_over;
                ends_clean = !i_tok.cont;
            end
            PH_LENGTH: begin
                err        = vint_over;
                ends_clean = !i_tok.cont && (acc_new == '0);
            end
            PH_SKIP: begin
                ends_clean = (r_skip == 64'd1);
            end
            default: begin
                err = 1'b0;
            end
        endcase
        if (!draining && i_tok.too_long) begin
            err = 1'b1;
        end
    end

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_sc    = r_sc;
        n_field = r_field;
        n_skip  = r_skip;
        if (o_pop) begin
            if (draining) begin
                if (i_tok.last) begin
                    n_phase = PH_TAG;
                end
            end else if (err) begin
                n_acc   = '0;
                n_sc    = '0;
                n_phase = i_tok.last ? PH_TAG : PH_DRAIN;
            end else begin
                case (r_phase)
                    PH_TAG, PH_VALUE, PH_LENGTH: begin
                        if (i_tok.cont) begin
                            n_acc = acc_new;
                            n_sc  = r_sc + 4'd1;
                        end else begin
                            n_acc = '0;
                            n_sc  = '0;
                            if (r_phase == PH_TAG) begin
                                n_field = acc_new[34:3];
                                case (wt)
                                    3'd0: n_phase = PH_VALUE;
                                    3'd2: n_phase = PH_LENGTH;
                                    3'd1: begin
                                        n_phase = PH_SKIP;
                                        n_skip  = 64'd8;
                                    end
                                    3'd5: begin
                                        n_phase = PH_SKIP;
                                        n_skip  = 64'd4;
                                    end
                                    default: n_phase = PH_TAG;
                                endcase
                            end else if (r_phase == PH_LENGTH && acc_new != '0) begin
                                n_phase = PH_SKIP;
                                n_skip  = acc_new;
                            end else begin
                                n_phase = PH_TAG;
                            end
                        end
                    end
                    PH_SKIP: begin
                        n_skip = r_skip - 64'd1;
                        if (r_skip == 64'd1) begin
                            n_phase = PH_TAG;
                        end
                    end
                    default: n_phase = r_phase;
                endcase
                if (i_tok.last) begin
                    n_phase = PH_TAG;
                    n_acc   = '0;
                    n_sc    = '0;
                end
            end
        end
    end

    // Result generation
    always_comb begin
        field_emit = o_pop && !draining && !err && !i_tok.cont &&
                     (r_phase == PH_VALUE || r_phase == PH_LENGTH);
        final_emit = o_pop && !draining && (err || i_tok.last);
        final_err  = err || !ends_clean;

        field_res.kind           = (r_phase == PH_LENGTH) ? KIND_LEN : KIND_VARINT;
        field_res.field_number   = r_field;
        field_res.field_value    = acc_new;
        field_res.payload_offset = (r_phase == PH_LENGTH) ? i_tok.pos : 16'd0;
        field_res.final_res      = 1'b0;

        final_out.kind           = (r_pend ? r_pend_err : final_err) ? KIND_ERR : KIND_OK;
        final_out.field_number   = '0;
        final_out.field_value    = '0;
        final_out.payload_offset = '0;
        final_out.final_res      = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_acc   <= '0;
            r_sc    <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_sc    <= n_sc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_field <= n_field;
        r_skip  <= n_skip;
    end

    // Output register; a final beat that follows a field beat waits in r_pend
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_err  <= 1'b0;
        end else if (r_pend && out_free) begin
            r_out_valid <= 1'b1;
            r_pend      <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= field_emit || final_emit;
            r_pend      <= field_emit && final_emit;
            r_pend_err  <= final_err;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && out_free) begin
            r_out <= final_out;
        end else if (o_pop && field_emit) begin
            r_out <= field_res;
        end else if (o_pop && final_emit) begin
            r_out <= final_out;
        end
    end

    a_pend_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_out_valid)
        else $error("pending final beat without a field beat in front");

    a_no_pop_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !o_pop)
        else $error("token popped while a final beat is pending");

    a_drain_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && r_phase == PH_DRAIN) |-> (!field_emit && !final_emit))
        else $error("result produced while draining an errored message");

    a_final_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.final_res == (r_out.kind == KIND_OK || r_out.kind == KIND_ERR)))
        else $error("final flag does not match result kind");

    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> (r_skip != '0))
        else $error("skip phase with nothing left to skip");

endmodule

### hdl/protobuf_wire_field_tokenizer_core.sv
// Wire-format field tokenizer, top level: front end, token queue, decoder.
// Depends on pbt_pkg, pbt_front, pbt_fifo, pbt_back.
//
// Input channel (i_valid/o_ready/i_data): one message byte per beat, with
// last_byte set on the final byte of each message. Output channel
// (o_valid/i_ready/o_res): one result per beat - a varint field, a
// length-delimited field (offset and length; payload bytes are skipped),
// then a final OK or decode-error beat closing every message.
// Path: an accepted byte is written into the token queue, popped by the
// decoder, and its result is registered in the result register that
// drives o_valid. Throughput is one byte per cycle while the receiver takes
// results; the decoder handles a byte each cycle, and only a last byte
// that also closes a field stalls it, since results leave one beat at a time.
// After an error, bytes up to and including the last one are swallowed.
// Reset (synchronous, active low) empties the token queue and the result
// register and starts a fresh message. When the receiver stalls, the
// result is held, the decoder stops, the four-entry token queue keeps
// taking bytes until full, then o_ready drops.
module protobuf_wire_field_tokenizer_core import pbt_pkg::*; #(
    parameter int unsigned MAX_MESSAGE_BYTES = 65536
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    logic q_full, q_empty, push, pop;
    t_tok tok_in, tok_out;

    pbt_front #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_q_full(q_full),
        .o_push  (push),
        .o_tok   (tok_in)
    );

    pbt_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_tok  (tok_in),
        .i_pop  (pop),
        .o_tok  (tok_out),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    pbt_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tok  (tok_out),
        .i_empty(q_empty),
        .o_pop  (pop),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_res  (o_res)
    );

endmodule

### sim/protobuf_wire_field_tokenizer_core_tb.sv
// Self-checking bench for protobuf_wire_field_tokenizer_core: a directed table and
// random well-formed and broken messages, scored against a byte-level decoder model
// kept here or against results written into the table rows. Depends on pbt_pkg and the RTL under hdl.
module protobuf_wire_field_tokenizer_core_tb;
    import pbt_pkg::*;

    localparam int unsigned MAX_BYTES  = 65536;
    localparam int          RAND_BEATS = 850;
    localparam int          LIMIT      = 1_000_000;

    localparam logic [2:0] WIRE_VARINT  = 3'd0;
    localparam logic [2:0] WIRE_FIXED64 = 3'd1;
    localparam logic [2:0] WIRE_LEN     = 3'd2;
    localparam logic [2:0] WIRE_SGROUP  = 3'd3;
    localparam logic [2:0] WIRE_EGROUP  = 3'd4;
    localparam logic [2:0] WIRE_FIXED32 = 3'd5;
    localparam logic [2:0] WIRE_RSVD6   = 3'd6;
    localparam logic [2:0] WIRE_RSVD7   = 3'd7;

    typedef struct {
        logic [7:0] data;
        logic       last_b;
        int         n_res;      // -1: results come from the decoder model
        t_res       r0;
        t_res       r1;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready = 1'b0;
    t_res o_res;

    always #5 i_clk = ~i_clk;

    protobuf_wire_field_tokenizer_core #(
        .MAX_MESSAGE_BYTES(MAX_BYTES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res)
    );

    // Decoder model state
    t_phase      dec_phase;
    logic [63:0] dec_acc;
    int unsigned dec_shift;
    logic [31:0] dec_field;
    logic [63:0] dec_skip;
    int unsigned dec_pos;

    t_res pending_results [$];
    t_row script [$];
    bit   jitter;
    int   stall_left = 0;
    int   errors     = 0;
    int   n_beats    = 0;
    int   n_msgs     = 0;
    int   n_checked  = 0;
    int   kind_seen [4] = '{0, 0, 0, 0};
    int   cycles     = 0;

    function automatic t_res mk_res(t_kind k, logic [31:0] f, logic [63:0] v, logic [15:0] o);
        t_res r;
        r.kind           = k;
        r.field_number   = f;
        r.field_value    = v;
        r.payload_offset = o;
        r.final_res      = (k == KIND_OK || k == KIND_ERR);
        return r;
    endfunction

    function automatic void dec_restart();
        dec_phase = PH_TAG;
        dec_acc   = '0;
        dec_shift = 0;
        dec_field = '0;
        dec_skip  = '0;
        dec_pos   = 0;
    endfunction

    // 1: varint complete, 0: more to come, -1: over-long
    function automatic int take_varint(logic [7:0] b);
        if (dec_shift > 9) return -1;
        dec_acc |= 64'(b[6:0]) << (7 * dec_shift);
        if (!b[7]) return 1;
        if (dec_shift >= 9) return -1;
        dec_shift++;
        return 0;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic l, output int n,
                               output t_res res [2]);
        logic        bad;
        int          st;
        logic [63:0] v;
        n      = 0;
        bad    = 1'b0;
        res[0] = '0;
        res[1] = '0;
        if (dec_phase == PH_DRAIN) begin
            if (l) dec_restart();
            return;
        end
        if (dec_pos >= MAX_BYTES) begin
            bad = 1'b1;
        end else begin
            dec_pos++;
            case (dec_phase)
                PH_TAG: begin
                    st = take_varint(b);
                    if (st < 0) begin
                        bad = 1'b1;
                    end else if (st > 0) begin
                        v         = dec_acc;
                        dec_acc   = '0;
                        dec_shift = 0;
                        dec_field = v[34:3];
                        case (v[2:0])
                            WIRE_VARINT: dec_phase = PH_VALUE;
                            WIRE_LEN:    dec_phase = PH_LENGTH;
                            WIRE_FIXED64: begin
                                dec_phase = PH_SKIP;
                                dec_skip  = 64'd8;
                            end
                            WIRE_FIXED32: begin
                                dec_phase = PH_SKIP;
                                dec_skip  = 64'd4;
                            end
                            default: bad = 1'b1;
                        endcase
                    end
                end
                PH_VALUE: begin
                    st = take_varint(b);
                    if (st < 0) begin
                        bad = 1'b1;
                    end else if (st > 0) begin
                        res[n] = mk_res(KIND_VARINT, dec_field, dec_acc, '0);
                        n++;
                        dec_acc   = '0;
                        dec_shift = 0;
                        dec_phase = PH_TAG;
                    end
                end
                PH_LENGTH: begin
                    st = take_varint(b);
                    if (st < 0) begin
                        bad = 1'b1;
                    end else if (st > 0) begin
                        v      = dec_acc;
                        res[n] = mk_res(KIND_LEN, dec_field, v, dec_pos[15:0]);
                        n++;
                        dec_acc   = '0;
                        dec_shift = 0;
                        if (v == 0) begin
                            dec_phase = PH_TAG;
                        end else begin
                            dec_phase = PH_SKIP;
                            dec_skip  = v;
                        end
                    end
                end
                PH_SKIP: begin
                    if (dec_skip != 0) dec_skip--;
                    if (dec_skip == 0) dec_phase = PH_TAG;
                end
                default: bad = 1'b1;
            endcase
        end
        if (bad) begin
            res[n] = mk_res(KIND_ERR, '0, '0, '0);
            n++;
            if (l) dec_restart();
            else dec_phase = PH_DRAIN;
        end else if (l) begin
            res[n] = mk_res((dec_phase == PH_TAG && dec_shift == 0) ? KIND_OK : KIND_ERR,
                            '0, '0, '0);
            n++;
            dec_restart();
        end
    endtask

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        if (errors <= 40)
            $display("t=%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    // Drive one beat; n_typed >= 0 replaces the model's results with t0/t1
    task automatic send_beat(input logic [7:0] b, input logic l, input int n_typed,
                             input t_res t0, input t_res t1);
        int   n;
        t_res got [2];
        if (jitter && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{data_byte: b, last_byte: l};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        decode_byte(b, l, n, got);
        if (n_typed >= 0) begin
            n      = n_typed;
            got[0] = t0;
            got[1] = t1;
        end
        for (int i = 0; i < n; i++) pending_results.push_back(got[i]);
        n_beats++;
        if (l) n_msgs++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic put_varint(ref logic [7:0] m [$], input logic [63:0] v, input int pad);
        int need;
        int total;
        need = 1;
        for (int i = 1; i < 10; i++)
            if ((v >> (7 * i)) != 0) need = i + 1;
        // padding adds redundant zero groups, never beyond ten bytes
        total = (need + pad > 10) ? 10 : need + pad;
        for (int i = 0; i < total; i++)
            m.push_back({1'(i != total - 1), 7'(v >> (7 * i))});
    endtask

    function automatic int pick_pad();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 9) : 0;
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 4))
            0:       return 64'd0;
            1:       return '1;
            2:       return 64'($urandom_range(0, 127));
            default: return {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
    endfunction

    function automatic logic [31:0] pick_field();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 32'($urandom_range(0, 15));
            6, 7:             return 32'($urandom_range(16, 4095));
            8:                return $urandom;
            default:          return '1;
        endcase
    endfunction

    task automatic add_field(ref logic [7:0] m [$], input logic [2:0] wt);
        logic [63:0] tag;
        logic [63:0] len;
        tag = {29'd0, pick_field(), wt};
        // tag bits above the 32-bit field number are dropped by the block
        if ($urandom_range(0, 19) == 0) tag[63:35] = 29'($urandom);
        put_varint(m, tag, pick_pad());
        case (wt)
            WIRE_VARINT: put_varint(m, pick_value(), pick_pad());
            WIRE_LEN: begin
                len = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(7, 40))
                                                  : 64'($urandom_range(0, 6));
                put_varint(m, len, pick_pad());
                repeat (len) m.push_back(8'($urandom));
            end
            WIRE_FIXED64: repeat (8) m.push_back(8'($urandom));
            WIRE_FIXED32: repeat (4) m.push_back(8'($urandom));
            default: ;  // group and reserved types: tag alone
        endcase
    endtask

    task automatic build_msg(ref logic [7:0] m [$]);
        int         mode;
        int         cut;
        logic [2:0] wt;
        m.delete();
        mode = $urandom_range(0, 99);
        if (mode >= 98) begin
            repeat ($urandom_range(1, 8)) m.push_back(8'($urandom));
            return;
        end
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: wt = WIRE_VARINT;
                4, 5, 6:    wt = WIRE_LEN;
                7:          wt = WIRE_FIXED64;
                default:    wt = WIRE_FIXED32;
            endcase
            add_field(m, wt);
        end
        if (mode >= 75 && mode < 85) begin
            // cut short: ends inside a tag, value, length or payload
            if (m.size() > 1) begin
                cut = $urandom_range(1, m.size() - 1);
                m   = m[0:cut - 1];
            end
        end else if (mode >= 85 && mode < 90) begin
            case ($urandom_range(0, 3))
                0:       wt = WIRE_SGROUP;
                1:       wt = WIRE_EGROUP;
                2:       wt = WIRE_RSVD6;
                default: wt = WIRE_RSVD7;
            endcase
            add_field(m, wt);
            repeat ($urandom_range(0, 3)) m.push_back(8'($urandom));
        end else if (mode >= 90 && mode < 95) begin
            // over-long varint (ten continuing bytes), either as tag or as value
            if ($urandom_range(0, 1) != 0) m.push_back(8'h08);
            repeat (10) m.push_back(8'($urandom) | 8'h80);
            repeat ($urandom_range(0, 3)) m.push_back(8'($urandom));
        end else if (mode >= 95) begin
            // length running past the end of the message
            put_varint(m, {29'd0, pick_field(), WIRE_LEN}, 0);
            put_varint(m, pick_value() | 64'h10, 0);
            repeat ($urandom_range(0, 4)) m.push_back(8'($urandom));
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (jitter && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 2);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result with nothing pending, kind", 64'(o_res.kind), 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_res.kind !== want.kind)
                    flag_mismatch("kind", 64'(o_res.kind), 64'(want.kind));
                if (o_res.field_number !== want.field_number)
                    flag_mismatch("field_number", 64'(o_res.field_number),
                                  64'(want.field_number));
                if (o_res.field_value !== want.field_value)
                    flag_mismatch("field_value", o_res.field_value, want.field_value);
                if (o_res.payload_offset !== want.payload_offset)
                    flag_mismatch("payload_offset", 64'(o_res.payload_offset),
                                  64'(want.payload_offset));
                if (o_res.final_res !== want.final_res)
                    flag_mismatch("final_res", 64'(o_res.final_res), 64'(want.final_res));
                n_checked++;
                kind_seen[want.kind]++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("timed out after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [7:0] msg [$];
        t_res       r_err;
        t_res       r_ok;
        t_res       r_none;
        int         n_rand;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        jitter  = 1'b0;
        n_rand  = 0;
        dec_restart();
        r_err  = mk_res(KIND_ERR, '0, '0, '0);
        r_ok   = mk_res(KIND_OK, '0, '0, '0);
        r_none = '0;

        // lone tag on the last beat: message ends inside a field
        script.push_back('{8'h08, 1'b1, 1, r_err, r_none});
        // field 1 = 150, clean end
        script.push_back('{8'h08, 1'b0, 0, r_none, r_none});
        script.push_back('{8'h96, 1'b0, 0, r_none, r_none});
        script.push_back('{8'h01, 1'b1, 2, mk_res(KIND_VARINT, 32'd1, 64'd150, '0), r_ok});
        // empty length-delimited field 2
        script.push_back('{8'h12, 1'b0, 0, r_none, r_none});
        script.push_back('{8'h00, 1'b1, 2, mk_res(KIND_LEN, 32'd2, 64'd0, 16'd2), r_ok});
        // group wire type mid-message, then the rest is swallowed
        script.push_back('{8'h0b, 1'b0, 1, r_err, r_none});
        script.push_back('{8'hff, 1'b0, 0, r_none, r_none});
        script.push_back('{8'h00, 1'b1, 0, r_none, r_none});
        // reserved wire type on the last beat
        script.push_back('{8'h0f, 1'b1, 1, r_err, r_none});
        // fixed32 skipped silently
        script.push_back('{8'h0d, 1'b0, -1, r_none, r_none});
        script.push_back('{8'h00, 1'b0, -1, r_none, r_none});
        script.push_back('{8'hff, 1'b0, -1, r_none, r_none});
        script.push_back('{8'h00, 1'b0, -1, r_none, r_none});
        script.push_back('{8'hff, 1'b1, -1, r_none, r_none});
        // tag whose tenth byte still continues
        repeat (9) script.push_back('{8'h80, 1'b0, -1, r_none, r_none});
        script.push_back('{8'hff, 1'b1, 1, r_err, r_none});

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        jitter = 1'b1;

        foreach (script[i])
            send_beat(script[i].data, script[i].last_b, script[i].n_res,
                      script[i].r0, script[i].r1);
        drain_results();

        while (n_rand < RAND_BEATS) begin
            jitter = (n_rand < RAND_BEATS - 120) && ($urandom_range(0, 3) != 0);
            build_msg(msg);
            foreach (msg[i]) send_beat(msg[i], i == msg.size() - 1, -1, r_none, r_none);
            n_rand += msg.size();
            if ($urandom_range(0, 39) == 0) drain_results();
        end
        jitter = 1'b0;
        drain_results();
        repeat (10) @(negedge i_clk);

        $display("%0d bytes in %0d messages; %0d results checked", n_beats, n_msgs, n_checked);
        $display("varint %0d, length %0d, ok %0d, error %0d; %0d mismatches",
                 kind_seen[KIND_VARINT], kind_seen[KIND_LEN], kind_seen[KIND_OK],
                 kind_seen[KIND_ERR], errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
hdl/pbt_pkg.sv
hdl/pbt_front.sv
hdl/pbt_fifo.sv
hdl/pbt_back.sv
hdl/protobuf_wire_field_tokenizer_core.sv
sim/protobuf_wire_field_tokenizer_core_tb.sv
